[hdl/pas_pkg.sv]
// ----------------------------------------------------------------------------
// pas_pkg
// shared types, constants and arctangent table for the pointing angle solver
// ----------------------------------------------------------------------------
`default_nettype none
package pas_pkg;

    localparam int CordicStepsDef  = 16;
    localparam int FractionBitsDef = 16;
    localparam int MaxSteps        = 32;

    localparam int InW  = 24;
    localparam int DW   = 25;
    localparam int AxW  = 20;
    localparam int AyW  = 19;
    localparam int CW   = 66;
    localparam int ZW   = 36;

    localparam logic [1:0] RegBaseX = 2'd0;
    localparam logic [1:0] RegBaseY = 2'd1;
    localparam logic [1:0] RegBaseH = 2'd2;

    // quadrant of the raw target x and y
    localparam logic [1:0] QuadPosPos = 2'd0;
    localparam logic [1:0] QuadPosNeg = 2'd1;
    localparam logic [1:0] QuadNegPos = 2'd2;
    localparam logic [1:0] QuadOther  = 2'd3;

    localparam logic signed [InW-1:0] BaseHReset = 24'sd39322;
    localparam longint PiQ32   = 64'h3243F6A89;
    localparam longint PiQ16   = 205887;
    localparam longint TwoPiQ16 = 411775;

    // floor of num / den for positive operands below 2^63, shift and subtract
    function automatic longint div_floor(input longint num, input longint den);
        longint q;
        longint rem;
        int b;
        q = 0;
        rem = 0;
        for (b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            if (rem >= den) begin
                rem = rem - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // atan(2^-i) in q.32, rounded
    function automatic longint atan_q32(input int i);
        longint s;
        longint term;
        int k;
        s = 0;
        if (i == 0) return (PiQ32 + 2) >>> 2;
        for (k = 0; k < 31; k++) begin
            if (i * (2 * k + 1) <= 60) begin
                term = div_floor(64'sd1 <<< (60 - i * (2 * k + 1)), longint'(2 * k + 1));
                s = k[0] ? s - term : s + term;
            end
        end
        return (s + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint q32_to_frac(input longint v, input int fb);
        return (v + (64'sd1 <<< (31 - fb))) >>> (32 - fb);
    endfunction

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic       neg_x;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_cord_in;

endpackage
`default_nettype wire

[hdl/pas_isqrt.sv]
// ----------------------------------------------------------------------------
// pas_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module pas_isqrt #(
    parameter int VW = 64,
    parameter int TW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [VW-1:0] i_v,
    input  wire logic [TW-1:0] i_tag,
    output logic [VW/2-1:0]    o_root,
    output logic [TW-1:0]      o_tag
);
    localparam int N = VW / 2;

    logic [VW-1:0]  r_rem  [1:N];
    logic [N-1:0]   r_res  [1:N];
    logic [TW-1:0]  r_tag  [1:N];

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [VW-1:0] n_rem;
        logic [N-1:0]  n_res;
        logic [TW-1:0] n_tag;
        logic [VW+1:0] n_trial;
        logic [VW+1:0] n_sub;
        if (s == 0) begin : g_first
            assign n_rem = i_v;
            assign n_res = '0;
            assign n_tag = i_tag;
        end else begin : g_next
            assign n_rem = r_rem[s];
            assign n_res = r_res[s];
            assign n_tag = r_tag[s];
        end
        always_comb begin
            n_trial = {2'b00, n_rem} >> (2 * (N - 1 - s));
            n_sub   = {{(VW - N){1'b0}}, n_res, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s+1] <= n_tag;
                if (n_trial >= n_sub) begin
                    r_rem[s+1] <= n_rem - VW'(n_sub << (2 * (N - 1 - s)));
                    r_res[s+1] <= {n_res[N-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_rem;
                    r_res[s+1] <= {n_res[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_res[N];
    assign o_tag  = r_tag[N];
endmodule
`default_nettype wire

[hdl/pas_cordic.sv]
// ----------------------------------------------------------------------------
// pas_cordic
// vectoring cordic atan2 with normalization, one stage per step
// ----------------------------------------------------------------------------
`default_nettype none
module pas_cordic #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16,
    parameter int TW = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire pas_pkg::t_cord_in    i_in,
    input  wire logic [TW-1:0]        i_tag,
    output logic signed [pas_pkg::ZW-1:0] o_z,
    output logic [TW-1:0]             o_tag
);
    import pas_pkg::*;

    localparam int SH = 6;
    localparam logic signed [ZW-1:0] HalfPi =
        ZW'(q32_to_frac(PiQ32, FRACTION_BITS) >>> 1);

    // stage 0: quadrant fix
    logic signed [CW-1:0] r_x0, r_y0;
    logic                 r_z0n, r_zero0;
    logic [TW-1:0]        r_t0;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0    <= i_in.neg_x ? i_in.y : i_in.x;
            r_y0    <= i_in.neg_x ? -i_in.x : i_in.y;
            r_z0n   <= i_in.neg_x;
            r_zero0 <= i_in.zero;
            r_t0    <= i_tag;
        end
    end

    // stage 1: leading-one position of max, in two parts
    logic signed [CW-1:0] r_x1, r_y1;
    logic [SH:0]          r_sh1;
    logic                 r_z1n, r_zero1;
    logic [TW-1:0]        r_t1;
    logic [CW-1:0]        n_m;
    logic [SH:0]          n_sh;
    always_comb begin
        n_m  = (r_x0 > r_y0) ? r_x0 : r_y0;
        n_sh = '0;
        for (int k = 0; k <= 40; k++) begin
            if (n_m[k]) n_sh = (SH+1)'(40 - k);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= r_x0;
            r_y1    <= r_y0;
            r_sh1   <= (n_m >= CW'(64'sd1 <<< 40)) ? '0 : n_sh;
            r_z1n   <= r_z0n;
            r_zero1 <= r_zero0 | (n_m == '0);
            r_t1    <= r_t0;
        end
    end

    logic signed [CW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];
    logic                 r_zr[CORDIC_STEPS+1];
    logic [TW-1:0]        r_t [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= r_x1 <<< r_sh1;
            r_y[0]  <= r_y1 <<< r_sh1;
            r_z[0]  <= r_z1n ? HalfPi : '0;
            r_zr[0] <= r_zero1;
            r_t[0]  <= r_t1;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [ZW-1:0] Ang =
            ZW'(q32_to_frac(atan_q32(i), FRACTION_BITS));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zr[i+1] <= r_zr[i];
                r_t[i+1]  <= r_t[i];
                if (!r_y[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + Ang;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - Ang;
                end
            end
        end
    end

    assign o_z   = r_zr[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];
    assign o_tag = r_t[CORDIC_STEPS];
endmodule
`default_nettype wire

[hdl/pointing_angle_solver.sv]
// throughput: one beat per cycle while the output is not stalled
// the whole pipeline advances together; a stall freezes every stage
// reset clears valid bits and loads base registers (height 0.6 m)
// ----------------------------------------------------------------------------
// pointing_angle_solver
// offsets, root, two cordic passes and sign selection in one pipeline
// ----------------------------------------------------------------------------
`default_nettype none
module pointing_angle_solver #(
    parameter int CORDIC_STEPS  = pas_pkg::CordicStepsDef,
    parameter int FRACTION_BITS = pas_pkg::FractionBitsDef
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [pas_pkg::InW-1:0]    i_target_x,
    input  wire logic signed [pas_pkg::InW-1:0]    i_target_y,
    input  wire logic signed [pas_pkg::InW-1:0]    i_target_z,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [pas_pkg::AxW-1:0]         o_angle_about_x,
    output logic signed [pas_pkg::AyW-1:0]         o_angle_about_y,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [pas_pkg::InW-1:0]           i_cfg_data
);
    import pas_pkg::*;

    // depth of one cordic pass and of the whole pipeline; meta rides as cordic tags
    localparam int DepC = CORDIC_STEPS + 3;
    localparam int Lat  = 2 + 32 + DepC + DepC + 1;

    logic r_bx, r_by, r_bh;
    logic signed [InW-1:0] r_base_x, r_base_y, r_base_h;
    logic en;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
            r_base_h <= BaseHReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegBaseX: r_base_x <= i_cfg_data;
                RegBaseY: r_base_y <= i_cfg_data;
                RegBaseH: r_base_h <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign r_bx = 1'b0;
    assign r_by = 1'b0;
    assign r_bh = 1'b0;

    // valid shift line
    logic [Lat-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[Lat-2:0], i_valid & ~(r_bx | r_by | r_bh)};
    end
    assign o_valid = r_vld[Lat-1];

    // stage: offsets
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    logic [1:0] r_q;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= DW'(i_target_x) - DW'(r_base_x);
            r_dy <= DW'(i_target_y) - DW'(r_base_y);
            r_dz <= DW'(i_target_z) - DW'(r_base_h);
            if (i_target_x > 0 && i_target_y > 0)      r_q <= QuadPosPos;
            else if (i_target_x > 0 && i_target_y < 0) r_q <= QuadPosNeg;
            else if (i_target_x < 0 && i_target_y > 0) r_q <= QuadNegPos;
            else                                       r_q <= QuadOther;
        end
    end

    // squares (one stage)
    logic [2*DW-1:0] r_sx, r_sz;
    logic signed [2*DW-1:0] n_px, n_pz;
    logic signed [DW-1:0] r_dx2, r_dy2, r_dz2;
    logic [1:0] r_q2;
    assign n_px = r_dx * r_dx;
    assign n_pz = r_dz * r_dz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx  <= unsigned'(n_px);
            r_sz  <= unsigned'(n_pz);
            r_dx2 <= r_dx;
            r_dy2 <= r_dy;
            r_dz2 <= r_dz;
            r_q2  <= r_q;
        end
    end

    localparam int TW1 = 3 * DW + 2 + 1;
    logic [63:0] n_r2s;
    logic [2*DW:0] n_r2;
    assign n_r2  = {1'b0, r_sx} + {1'b0, r_sz};
    assign n_r2s = 64'(n_r2) << 14;

    logic [31:0] s_root;
    logic [TW1-1:0] s_tag;
    pas_isqrt #(.VW(64), .TW(TW1)) u_sqrt (
        .i_clk (i_clk), .i_en(en), .i_v(n_r2s),
        .i_tag ({r_dx2, r_dy2, r_dz2, r_q2, n_r2 != '0}),
        .o_root(s_root), .o_tag(s_tag)
    );
    // the sqrt stages are counted in Lat, as is the squares stage that feeds it

    logic signed [DW-1:0] s_dx, s_dy, s_dz;
    logic [1:0] s_q;
    logic s_nz;
    assign {s_dx, s_dy, s_dz, s_q, s_nz} = s_tag;

    // cordic for a
    t_cord_in n_ain;
    logic signed [DW-1:0] n_ady, n_adx;
    assign n_ady = s_dy[DW-1] ? -s_dy : s_dy;
    assign n_adx = s_dx[DW-1] ? -s_dx : s_dx;
    always_comb begin
        n_ain.valid = 1'b1;
        n_ain.zero  = !(s_nz && s_dy != '0);
        n_ain.neg_x = 1'b0;
        n_ain.x     = CW'($signed({1'b0, s_root}));
        n_ain.y     = CW'(n_ady) <<< 7;
    end
    localparam int TW2 = DW + DW + 2 + 1;
    logic signed [ZW-1:0] a_z;
    logic [TW2-1:0] a_tag;
    pas_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FRACTION_BITS), .TW(TW2)) u_ca (
        .i_clk(i_clk), .i_en(en), .i_in(n_ain),
        .i_tag({n_adx, s_dz, s_q, (s_dx[DW-1] != s_dy[DW-1]) && s_dx != '0 && !n_ain.zero}),
        .o_z(a_z), .o_tag(a_tag)
    );
    logic signed [DW-1:0] c_adx, c_dz;
    logic [1:0] c_q;
    logic c_flip;
    assign {c_adx, c_dz, c_q, c_flip} = a_tag;

    // cordic for b, carries a
    t_cord_in n_bin;
    logic signed [ZW-1:0] n_a;
    assign n_a = c_flip ? ZW'(2 * q32_to_frac(PiQ32, FRACTION_BITS)) - a_z : a_z;
    always_comb begin
        n_bin.valid = 1'b1;
        n_bin.zero  = (c_adx == '0) && (c_dz == '0);
        n_bin.neg_x = c_dz[DW-1];
        n_bin.x     = CW'(c_dz);
        n_bin.y     = CW'(c_adx);
    end
    localparam int TW3 = ZW + 2;
    logic signed [ZW-1:0] b_z;
    logic [TW3-1:0] b_tag;
    pas_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FRACTION_BITS), .TW(TW3)) u_cb (
        .i_clk(i_clk), .i_en(en), .i_in(n_bin),
        .i_tag({n_a, c_q}), .o_z(b_z), .o_tag(b_tag)
    );

    // rounding, clamp and signs
    logic signed [ZW-1:0] e_a;
    logic [1:0] e_q;
    assign {e_a, e_q} = b_tag;

    function automatic logic signed [ZW+8:0] to_q16(input logic signed [ZW-1:0] z);
        logic signed [ZW+8:0] w;
        w = (ZW+9)'(z);
        if (FRACTION_BITS > 16)
            return (w + ((ZW+9)'(1) <<< (FRACTION_BITS - 17))) >>> (FRACTION_BITS - 16);
        else
            return w <<< (16 - FRACTION_BITS);
    endfunction

    logic signed [ZW+8:0] n_qa, n_qb;
    logic signed [AxW-1:0] n_ca;
    logic signed [AyW-1:0] n_cb;
    always_comb begin
        n_qa = to_q16(e_a);
        n_qb = to_q16(b_z);
        if (n_qa < 0) n_ca = '0;
        else if (n_qa > (ZW+9)'(TwoPiQ16)) n_ca = AxW'(TwoPiQ16);
        else n_ca = AxW'(n_qa);
        if (n_qb < 0) n_cb = '0;
        else if (n_qb > (ZW+9)'(PiQ16)) n_cb = AyW'(PiQ16);
        else n_cb = AyW'(n_qb);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (e_q)
                QuadPosPos: begin o_angle_about_x <= -n_ca; o_angle_about_y <= n_cb; end
                QuadPosNeg: begin o_angle_about_x <= n_ca;  o_angle_about_y <= n_cb; end
                QuadNegPos: begin o_angle_about_x <= -n_ca; o_angle_about_y <= -n_cb; end
                default: begin o_angle_about_x <= n_ca; o_angle_about_y <= -n_cb; end
            endcase
        end
    end
endmodule
`default_nettype wire
